// ===== src/throughput_clock_governor_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the throughput clock governor
// Concurrent checks that compile to nothing when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef THROUGHPUT_CLOCK_GOVERNOR_UNIT_ASSERT_SVH
`define THROUGHPUT_CLOCK_GOVERNOR_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
// check a property on the rising clock, held off during reset
`define TCG_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("tcg assertion failed");
// check a property on every rising clock, reset included
`define TCG_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("tcg assertion failed");
`else
`define TCG_ASSERT(lbl, clk, rst_n, prop)
`define TCG_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// ===== src/tcg_pkg.sv =====
// ----------------------------------------------------------------------------
// Throughput clock governor package
// Request and result types, state encoding, frequency constants and lookups.
// ----------------------------------------------------------------------------
package tcg_pkg;

  localparam int RATE_BITS  = 32;
  localparam int COUNT_BITS = 22;
  localparam int ELAP_BITS  = 16;
  localparam int RATE_SHIFT = 10;
  localparam int TICK_BITS  = 16;
  localparam int CFG_BITS   = 63;
  localparam int LVL_BITS   = 2;
  localparam int FREQ_BITS  = 9;
  localparam int TCLS_BITS  = 2;

  localparam logic [LVL_BITS-1:0]  TOP_LEVEL  = 2'd3;
  localparam logic [LVL_BITS-1:0]  IDLE_LEVEL = 2'd0;
  localparam logic [TICK_BITS-1:0] TICK_MAX   = 16'hFFFF;

  localparam logic OP_TICK   = 1'b0;
  localparam logic OP_BUFFER = 1'b1;

  localparam logic [FREQ_BITS-1:0] FREQ_40  = 9'd40;
  localparam logic [FREQ_BITS-1:0] FREQ_80  = 9'd80;
  localparam logic [FREQ_BITS-1:0] FREQ_160 = 9'd160;
  localparam logic [FREQ_BITS-1:0] FREQ_240 = 9'd240;
  localparam logic [FREQ_BITS-1:0] FREQ_480 = 9'd480;

  localparam logic [1:0] BW_VHT80 = 2'd3;

  localparam logic [TCLS_BITS-1:0] TCLS_IDLE   = 2'd0;
  localparam logic [TCLS_BITS-1:0] TCLS_MEDIUM = 2'd1;
  localparam logic [TCLS_BITS-1:0] TCLS_BUSY   = 2'd2;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_BA_LIMITS    = 3'd0,
    CFG_PLAIN_LIMITS = 3'd1,
    CFG_BUSY_TICKS   = 3'd2,
    CFG_IDLE_TICKS   = 3'd3,
    CFG_BUF_MARK     = 3'd4,
    CFG_AUTO_EN      = 3'd5,
    CFG_PS_EN        = 3'd6
  } tcg_cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_CLASS,
    ST_UPDATE
  } tcg_state_e;

  typedef struct packed {
    logic                  opcode;
    logic [COUNT_BITS-1:0] packet_count;
    logic [ELAP_BITS-1:0]  elapsed_ms;
    logic                  ba_active;
    logic [1:0]            bw_class;
    logic [15:0]           free_buffers;
  } tcg_in_t;

  typedef struct packed {
    logic                 freq_changed;
    logic [FREQ_BITS-1:0] cpu_freq_mhz;
    logic [LVL_BITS-1:0]  active_level;
    logic [LVL_BITS-1:0]  wanted_level;
    logic [TCLS_BITS-1:0] timeout_class;
    logic [RATE_BITS-1:0] rate_value;
  } tcg_out_t;

  // frequency for a bandwidth class and level
  function automatic logic [FREQ_BITS-1:0] freq_lookup(logic [1:0] bw,
                                                      logic [LVL_BITS-1:0] lvl);
    logic [FREQ_BITS-1:0] f;
    case (lvl)
      2'd0:    f = (bw == BW_VHT80) ? FREQ_80 : FREQ_40;
      2'd1:    f = FREQ_160;
      2'd2:    f = FREQ_240;
      default: f = FREQ_480;
    endcase
    return f;
  endfunction

  // power timer class implied by a frequency
  function automatic logic [TCLS_BITS-1:0] timeout_of(logic [FREQ_BITS-1:0] f);
    logic [TCLS_BITS-1:0] c;
    if (f < FREQ_80) begin
      c = TCLS_IDLE;
    end else if (f < FREQ_160) begin
      c = TCLS_MEDIUM;
    end else begin
      c = TCLS_BUSY;
    end
    return c;
  endfunction

endpackage

// ===== src/tcg_div.sv =====
// ----------------------------------------------------------------------------
// Bit-serial rate divider
// Restoring division of a 32-bit dividend by a 16-bit divisor, one quotient
// bit per cycle, shifted through a single dividend/quotient register.
// ----------------------------------------------------------------------------
`include "throughput_clock_governor_unit_assert.svh"

module tcg_div
  import tcg_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [RATE_BITS-1:0] dividend_i,
  input  logic [ELAP_BITS-1:0] divisor_i,
  output logic                 done_o,
  output logic [RATE_BITS-1:0] quotient_o
);

  localparam int CNT_BITS = $clog2(RATE_BITS);
  localparam logic [CNT_BITS-1:0] LAST_STEP = CNT_BITS'(RATE_BITS - 1);

  logic                 busy_q, busy_d;
  logic [CNT_BITS-1:0]  cnt_q, cnt_d;
  logic [RATE_BITS-1:0] dq_q, dq_d;
  logic [ELAP_BITS-1:0] rem_q, rem_d;
  logic [ELAP_BITS-1:0] dvs_q, dvs_d;
  logic [ELAP_BITS:0]   rem_sh;
  logic [ELAP_BITS:0]   rem_sub;
  logic                 qbit;

  // shift in the next dividend bit and try the subtract
  assign rem_sh  = {rem_q, dq_q[RATE_BITS-1]};
  assign rem_sub = rem_sh - {1'b0, dvs_q};
  assign qbit    = (rem_sh >= {1'b0, dvs_q});

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    dq_d   = dq_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dq_d   = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      dq_d  = {dq_q[RATE_BITS-2:0], qbit};
      rem_d = qbit ? rem_sub[ELAP_BITS-1:0] : rem_sh[ELAP_BITS-1:0];
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == LAST_STEP) begin
        busy_d = 1'b0;
      end
    end
  end

  // hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  // advance the datapath
  always_ff @(posedge clk_i) begin
    dq_q  <= dq_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = busy_q && (cnt_q == LAST_STEP);
  assign quotient_o = {dq_q[RATE_BITS-2:0], qbit};

  `TCG_ASSERT(a_start_idle, clk_i, rst_ni, start_i |-> !busy_q)
  `TCG_ASSERT(a_done_pulse, clk_i, rst_ni, done_o |=> !done_o)
  `TCG_ASSERT(a_done_busy, clk_i, rst_ni, done_o |=> !busy_q)

endmodule

// ===== src/throughput_clock_governor_unit.sv =====
// ----------------------------------------------------------------------------
// Throughput clock governor
// Selects a CPU clock level from traffic rate ticks and free buffer reports.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on in_valid_i/in_stall_o/in_data_i. opcode 0 is a rate
//   tick, opcode 1 a free buffer report. Each request yields exactly one
//   result on out_valid_o/out_stall_i/out_data_o, in request order.
//   A tick with nonzero elapsed_ms runs a bit-serial divider for
//   (packet_count * 1024) / elapsed_ms, one quotient bit per cycle.
//   One request is in flight at a time; the next can be accepted in the
//   same cycle that the result is offered.
//   The result sits in an output register; the next request is accepted
//   while it waits, and the new request waits at its last step while the
//   receiver stalls.
//   Configuration writes on cfg_valid_i/cfg_ready_o are always taken and
//   are meant for idle periods. Reset restores configuration and control
//   registers: automatic selection on, level idle, 40 MHz applied.
// ----------------------------------------------------------------------------
`include "throughput_clock_governor_unit_assert.svh"

module throughput_clock_governor_unit
  import tcg_pkg::*;
#(
  parameter int LIMIT_BITS = 21
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  tcg_in_t             in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output tcg_out_t            out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [2:0]          cfg_index_i,
  input  logic [CFG_BITS-1:0] cfg_data_i
);

  localparam int LIM_W = 3 * LIMIT_BITS;

  // configuration
  logic [LIM_W-1:0]     ba_lim_q, plain_lim_q;
  logic [TICK_BITS-1:0] busy_ticks_q, idle_ticks_q, buf_mark_q;
  logic                 auto_en_q, ps_en_q;

  // governor state
  tcg_state_e           state_q, state_d;
  tcg_in_t              item_q;
  logic [RATE_BITS-1:0] rate_q;
  logic [LVL_BITS-1:0]  class_q;
  logic [LVL_BITS-1:0]  applied_q, applied_d;
  logic [LVL_BITS-1:0]  req_q, req_d;
  logic [TICK_BITS-1:0] dcnt_q, dcnt_d;
  logic [FREQ_BITS-1:0] freq_q, freq_d;
  logic [TCLS_BITS-1:0] tcls_q, tcls_d;
  logic                 out_valid_q;
  tcg_out_t             out_q;

  logic                 accept;
  logic                 div_start, div_done;
  logic [RATE_BITS-1:0] div_quot;
  logic                 do_update;
  logic                 changed;
  logic [LVL_BITS-1:0]  new_level;
  logic [LVL_BITS-1:0]  class_d;
  logic [LIM_W-1:0]     lim_sel;
  logic [RATE_BITS-1:0] t1, t2, t3;
  logic [TICK_BITS-1:0] dcnt_inc, dn_limit;

  assign accept      = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign div_start   = accept && (in_data_i.opcode == OP_TICK) &&
                       (in_data_i.elapsed_ms != '0);

  tcg_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i ({in_data_i.packet_count, RATE_SHIFT'(0)}),
    .divisor_i  (in_data_i.elapsed_ms),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  // write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ba_lim_q     <= '0;
      plain_lim_q  <= '0;
      busy_ticks_q <= '0;
      idle_ticks_q <= '0;
      buf_mark_q   <= '0;
      auto_en_q    <= 1'b1;
      ps_en_q      <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_BA_LIMITS:    ba_lim_q     <= cfg_data_i[LIM_W-1:0];
        CFG_PLAIN_LIMITS: plain_lim_q  <= cfg_data_i[LIM_W-1:0];
        CFG_BUSY_TICKS:   busy_ticks_q <= cfg_data_i[TICK_BITS-1:0];
        CFG_IDLE_TICKS:   idle_ticks_q <= cfg_data_i[TICK_BITS-1:0];
        CFG_BUF_MARK:     buf_mark_q   <= cfg_data_i[TICK_BITS-1:0];
        CFG_AUTO_EN:      auto_en_q    <= cfg_data_i[0];
        CFG_PS_EN:        ps_en_q      <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // classify the last rate against the selected threshold set
  assign lim_sel = item_q.ba_active ? ba_lim_q : plain_lim_q;
  assign t1 = RATE_BITS'(lim_sel[LIMIT_BITS-1:0]);
  assign t2 = RATE_BITS'(lim_sel[2*LIMIT_BITS-1:LIMIT_BITS]);
  assign t3 = RATE_BITS'(lim_sel[LIM_W-1:2*LIMIT_BITS]);

  always_comb begin
    if (rate_q <= t1) begin
      class_d = 2'd0;
    end else if (rate_q <= t2) begin
      class_d = 2'd1;
    end else if (rate_q <= t3) begin
      class_d = 2'd2;
    end else begin
      class_d = TOP_LEVEL;
    end
  end

  assign dcnt_inc = (dcnt_q == TICK_MAX) ? dcnt_q : dcnt_q + 1'b1;
  assign dn_limit = (item_q.packet_count != '0) ? busy_ticks_q : idle_ticks_q;
  assign do_update = (state_q == ST_UPDATE) && !(out_valid_q && out_stall_i);

  // sequence the request and work out the level decision
  always_comb begin
    state_d   = state_q;
    req_d     = req_q;
    dcnt_d    = dcnt_q;
    changed   = 1'b0;
    new_level = applied_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = div_start ? ST_DIV : ST_CLASS;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_CLASS;
        end
      end
      ST_CLASS: begin
        state_d = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (do_update) begin
          state_d = ST_IDLE;
          if (item_q.opcode == OP_TICK) begin
            if (auto_en_q) begin
              req_d = class_q;
              if (class_q == applied_q) begin
                dcnt_d = '0;
              end else if (class_q < applied_q) begin
                // lower only after enough consecutive ticks
                if (dcnt_inc >= dn_limit) begin
                  dcnt_d    = '0;
                  changed   = 1'b1;
                  new_level = class_q;
                end else begin
                  dcnt_d = dcnt_inc;
                end
              end else begin
                // raise straight to the top level
                dcnt_d    = '0;
                req_d     = TOP_LEVEL;
                changed   = 1'b1;
                new_level = TOP_LEVEL;
              end
            end
          end else if (auto_en_q && ps_en_q && (applied_q != TOP_LEVEL) &&
                       ({1'b0, item_q.free_buffers} <= {1'b0, buf_mark_q} + 17'd1)) begin
            req_d     = TOP_LEVEL;
            changed   = 1'b1;
            new_level = TOP_LEVEL;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // apply a level change
  always_comb begin
    applied_d = applied_q;
    freq_d    = freq_q;
    tcls_d    = tcls_q;
    if (changed) begin
      applied_d = new_level;
      freq_d    = freq_lookup(item_q.bw_class, new_level);
      tcls_d    = timeout_of(freq_d);
    end
  end

  // hold control and governor state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rate_q      <= '0;
      applied_q   <= IDLE_LEVEL;
      req_q       <= IDLE_LEVEL;
      dcnt_q      <= '0;
      freq_q      <= FREQ_40;
      tcls_q      <= TCLS_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      req_q     <= req_d;
      dcnt_q    <= dcnt_d;
      applied_q <= applied_d;
      freq_q    <= freq_d;
      tcls_q    <= tcls_d;
      if (div_done) begin
        rate_q <= div_quot;
      end
      if (do_update) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // capture the request, the class and the result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_data_i;
    end
    if (state_q == ST_CLASS) begin
      class_q <= class_d;
    end
    if (do_update) begin
      out_q.freq_changed  <= changed;
      out_q.cpu_freq_mhz  <= freq_d;
      out_q.active_level  <= applied_d;
      out_q.wanted_level  <= req_d;
      out_q.timeout_class <= tcls_d;
      out_q.rate_value    <= rate_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `TCG_ASSERT(a_change_settles, clk_i, rst_ni,
              (out_valid_o && out_data_o.freq_changed) |->
              (out_data_o.active_level == out_data_o.wanted_level))
  `TCG_ASSERT_ALWAYS(a_top_freq, clk_i,
                     (applied_q == TOP_LEVEL) |-> (freq_q == FREQ_480))
  `TCG_ASSERT(a_tcls_match, clk_i, rst_ni, tcls_q == timeout_of(freq_q))

endmodule
